// File: rtl/wmc_pkg.sv
// ----------------------------------------------------------------------------
// wmc_pkg
// Shared codes and control types of the weighted mean and covariance block.
// ----------------------------------------------------------------------------
package wmc_pkg;

    typedef enum logic [2:0] {
        ACT_LOAD_COMP = 3'd0,
        ACT_LOAD_WGT  = 3'd1,
        ACT_COMPUTE   = 3'd2,
        ACT_READ_MEAN = 3'd3,
        ACT_READ_COV  = 3'd4
    } t_action;

    typedef struct packed {
        logic clear;
        logic wr_en;
    } t_tri_ctrl;

endpackage

// File: rtl/wmc_fxmul.sv
// ----------------------------------------------------------------------------
// wmc_fxmul
// Shared fixed point multiplier: truncating, wrapping, registered product.
// ----------------------------------------------------------------------------
module wmc_fxmul #(
    parameter int WORD_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         i_clk,
    input  logic signed [WORD_WIDTH-1:0] i_a,
    input  logic signed [WORD_WIDTH-1:0] i_b,
    output logic signed [WORD_WIDTH-1:0] o_prod
);
    logic signed [2*WORD_WIDTH-1:0]           full;
    logic signed [2*WORD_WIDTH+FRAC_BITS-1:0] ext;
    logic signed [WORD_WIDTH-1:0]             r_prod;

    assign full = i_a * i_b;
    assign ext  = (2*WORD_WIDTH+FRAC_BITS)'(full);

    always_ff @(posedge i_clk) begin
        r_prod <= ext[FRAC_BITS+WORD_WIDTH-1:FRAC_BITS];
    end

    assign o_prod = r_prod;
endmodule

// File: rtl/wmc_tri.sv
// ----------------------------------------------------------------------------
// wmc_tri
// Upper triangle accumulator memory with per-entry valid bits (invalid = 0).
// ----------------------------------------------------------------------------
module wmc_tri #(
    parameter int DEPTH      = 91,
    parameter int WORD_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  wmc_pkg::t_tri_ctrl            i_ctrl,
    input  logic [$clog2(DEPTH+1)-1:0]    i_rd_addr,
    input  logic [$clog2(DEPTH+1)-1:0]    i_wr_addr,
    input  logic signed [WORD_WIDTH-1:0]  i_wr_data,
    output logic signed [WORD_WIDTH-1:0]  o_rd_data
);
    localparam int AW = $clog2(DEPTH+1);

    logic signed [WORD_WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0]             r_valid;
    logic signed [WORD_WIDTH-1:0] r_rd_data;
    logic                         r_rd_ok;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            r_rd_ok <= (i_rd_addr < AW'(DEPTH)) && r_valid[i_rd_addr];
            if (i_ctrl.clear) begin
                r_valid <= '0;
            end else if (i_ctrl.wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
        end
    end

    assign o_rd_data = r_rd_ok ? r_rd_data : '0;
endmodule

// File: rtl/weighted_mean_covariance_top.sv
// ----------------------------------------------------------------------------
// weighted_mean_covariance_top
// Particle set weighted mean and upper triangle covariance, one shared multiplier.
// ----------------------------------------------------------------------------
// Loads and mean reads keep the sequencer idle; a mean read result is registered and
// appears in the cycle after its request. A covariance read holds intake in
// its read state, and its result passes the triangle read register and then
// the output register. A compute request holds intake while the means (read,
// multiply, add per component and particle), then per particle the covariance
// (subtract per component, load per row, two multiplies and add per entry) are
// formed, every product passing in turn through the single registered multiplier.
module weighted_mean_covariance_top #(
    parameter int NUM_STATE   = 13,
    parameter int NUM_SAMPLES = 1024,
    parameter int WORD_WIDTH  = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_action,
    input  logic [9:0]         i_particle_index,
    input  logic [3:0]         i_row_index,
    input  logic [3:0]         i_column_index,
    input  logic signed [31:0] i_sample_value,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_read_value
);
    localparam int SW      = (NUM_STATE > 1) ? $clog2(NUM_STATE) : 1;
    localparam int PW      = (NUM_SAMPLES > 1) ? $clog2(NUM_SAMPLES) : 1;
    localparam int TRI_LEN = NUM_STATE * (NUM_STATE + 1) / 2;
    localparam int TW      = $clog2(TRI_LEN + 1);
    localparam int PDEPTH  = NUM_STATE * NUM_SAMPLES;
    localparam int PAW     = $clog2(PDEPTH);
    localparam int W       = WORD_WIDTH;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_M_RD  = 11'b00000000010,
        S_M_MUL = 11'b00000000100,
        S_M_ACC = 11'b00000001000,
        S_D_RD  = 11'b00000010000,
        S_D_SUB = 11'b00000100000,
        S_C_LDI = 11'b00001000000,
        S_C_MU1 = 11'b00010000000,
        S_C_MU2 = 11'b00100000000,
        S_C_ACC = 11'b01000000000,
        S_RDC   = 11'b10000000000
    } t_state;

    t_state              r_state;
    logic [SW-1:0]       r_row, r_i, r_j;
    logic [PW-1:0]       r_p;
    logic [TW-1:0]       r_k;
    logic signed [W-1:0] r_sum, r_x, r_w, r_wt, r_di;
    logic signed [W-1:0] r_mean [NUM_STATE];
    logic signed [W-1:0] r_diff [NUM_STATE];
    logic signed [W-1:0] pmem [PDEPTH];
    logic signed [W-1:0] wmem [NUM_SAMPLES];
    logic                r_out_valid, r_rng;
    logic signed [31:0]  r_out_data;

    logic                in_fire, row_ok, col_ok, pidx_ok;
    logic signed [63:0]  val_ext, mean_ext, tri_ext;
    logic signed [W-1:0] val_w, mul_a, mul_b, prod, diff_rd, mean_rd, tri_rd;
    logic [SW-1:0]       mean_idx, diff_idx;
    logic [PAW-1:0]      rd_paddr, wr_paddr;
    logic [15:0]         tr, tc, tidx;
    logic [TW-1:0]       tri_raddr;
    wmc_pkg::t_tri_ctrl  tri_ctrl;

    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign in_fire    = i_in_valid && o_in_ready;
    assign row_ok     = {1'b0, i_row_index} < 5'(NUM_STATE);
    assign col_ok     = {1'b0, i_column_index} < 5'(NUM_STATE);
    assign pidx_ok    = 13'(i_particle_index) < 13'(NUM_SAMPLES);
    assign val_ext    = 64'(i_sample_value);
    assign val_w      = val_ext[W-1:0];

    assign rd_paddr = PAW'(r_row * NUM_SAMPLES) + PAW'(r_p);
    assign wr_paddr = PAW'(i_row_index[SW-1:0] * NUM_SAMPLES) + PAW'(PW'(i_particle_index));

    assign mean_idx = (r_state == S_IDLE) ? i_row_index[SW-1:0] : r_row;
    assign mean_rd  = r_mean[mean_idx];
    assign mean_ext = 64'(mean_rd);
    assign diff_idx = (r_state == S_C_LDI) ? r_i : r_j;
    assign diff_rd  = r_diff[diff_idx];

    // row-major upper triangle index, lower triangle mirrored
    always_comb begin
        if (i_row_index > i_column_index) begin
            tr = 16'(i_column_index);
            tc = 16'(i_row_index);
        end else begin
            tr = 16'(i_row_index);
            tc = 16'(i_column_index);
        end
        tidx = tr * 16'(NUM_STATE) - ((tr * (tr - 16'd1)) >> 1) + (tc - tr);
    end
    assign tri_raddr = (r_state == S_IDLE) ? tidx[TW-1:0] : r_k;

    always_comb begin
        case (r_state)
            S_C_MU1: begin
                mul_a = r_di;
                mul_b = diff_rd;
            end
            S_C_MU2: begin
                mul_a = prod;
                mul_b = r_wt;
            end
            default: begin
                mul_a = r_x;
                mul_b = r_w;
            end
        endcase
    end

    assign tri_ctrl.clear = in_fire && (i_action == wmc_pkg::ACT_COMPUTE);
    assign tri_ctrl.wr_en = (r_state == S_C_ACC);

    wmc_fxmul #(.WORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    wmc_tri #(.DEPTH(TRI_LEN), .WORD_WIDTH(W)) u_tri (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (tri_ctrl),
        .i_rd_addr (tri_raddr),
        .i_wr_addr (r_k),
        .i_wr_data (tri_rd + prod),
        .o_rd_data (tri_rd)
    );
    assign tri_ext = 64'(tri_rd);

    always_ff @(posedge i_clk) begin
        if (in_fire && (i_action == wmc_pkg::ACT_LOAD_COMP) && pidx_ok && row_ok) begin
            pmem[wr_paddr] <= val_w;
        end
        r_x <= pmem[rd_paddr];
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && (i_action == wmc_pkg::ACT_LOAD_WGT) && pidx_ok) begin
            wmem[PW'(i_particle_index)] <= val_w;
        end
        r_w <= wmem[r_p];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row       <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_p         <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
            r_rng       <= 1'b0;
            for (int n = 0; n < NUM_STATE; n++) begin
                r_mean[n] <= '0;
            end
        end else begin
            if (in_fire && (i_action == wmc_pkg::ACT_READ_MEAN)) begin
                r_out_valid <= 1'b1;
                r_out_data  <= row_ok ? mean_ext[31:0] : '0;
            end else if (r_state == S_RDC) begin
                r_out_valid <= 1'b1;
                r_out_data  <= r_rng ? tri_ext[31:0] : '0;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        case (i_action)
                            wmc_pkg::ACT_COMPUTE: begin
                                r_row   <= '0;
                                r_p     <= '0;
                                r_sum   <= '0;
                                r_state <= S_M_RD;
                            end
                            wmc_pkg::ACT_READ_COV: begin
                                r_rng   <= row_ok && col_ok;
                                r_state <= S_RDC;
                            end
                            default: ;
                        endcase
                    end
                end
                S_RDC:   r_state <= S_IDLE;
                S_M_RD:  r_state <= S_M_MUL;
                S_M_MUL: r_state <= S_M_ACC;
                S_M_ACC: begin
                    if (r_p == PW'(NUM_SAMPLES - 1)) begin
                        r_mean[r_row] <= r_sum + prod;
                        r_sum         <= '0;
                        r_p           <= '0;
                        r_row         <= (r_row == SW'(NUM_STATE - 1)) ? '0 : r_row + 1'b1;
                        r_state       <= (r_row == SW'(NUM_STATE - 1)) ? S_D_RD : S_M_RD;
                    end else begin
                        r_sum   <= r_sum + prod;
                        r_p     <= r_p + 1'b1;
                        r_state <= S_M_RD;
                    end
                end
                S_D_RD: r_state <= S_D_SUB;
                S_D_SUB: begin
                    r_diff[r_row] <= r_x - mean_rd;
                    r_wt          <= r_w;
                    if (r_row == SW'(NUM_STATE - 1)) begin
                        r_row   <= '0;
                        r_i     <= '0;
                        r_k     <= '0;
                        r_state <= S_C_LDI;
                    end else begin
                        r_row   <= r_row + 1'b1;
                        r_state <= S_D_RD;
                    end
                end
                S_C_LDI: begin
                    r_di    <= diff_rd;
                    r_j     <= r_i;
                    r_state <= S_C_MU1;
                end
                S_C_MU1: r_state <= S_C_MU2;
                S_C_MU2: r_state <= S_C_ACC;
                S_C_ACC: begin
                    r_k <= r_k + 1'b1;
                    if (r_j != SW'(NUM_STATE - 1)) begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_C_MU1;
                    end else if (r_i != SW'(NUM_STATE - 1)) begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_C_LDI;
                    end else if (r_p != PW'(NUM_SAMPLES - 1)) begin
                        r_p     <= r_p + 1'b1;
                        r_state <= S_D_RD;
                    end else begin
                        r_p     <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_out_data;

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (r_state == S_IDLE))
        else $error("intake open outside idle");

    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("sequencer state not one-hot");

    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_C_ACC) |-> (r_k < TW'(TRI_LEN) && r_i <= r_j))
        else $error("triangle index out of range");

    a_cov_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RDC) |=> r_out_valid)
        else $error("covariance read lost its result");
endmodule

// File: sim/weighted_mean_covariance_checker.sv
// ----------------------------------------------------------------------------
// weighted_mean_covariance_checker
// Watches both channels of the block, keeps its own copy of the particle,
// weight, mean and covariance stores, predicts every read result and compares
// it with the one the block returns.
// ----------------------------------------------------------------------------
module weighted_mean_covariance_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [2:0]         i_action,
    input  logic [9:0]         i_particle_index,
    input  logic [3:0]         i_row_index,
    input  logic [3:0]         i_column_index,
    input  logic signed [31:0] i_sample_value,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic signed [31:0] i_read_value,
    output int                 o_failures,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_STATE = 13;
    localparam int N_SAMP  = 1024;
    localparam int N_TRI   = N_STATE * (N_STATE + 1) / 2;

    logic signed [31:0] comp_mem [N_STATE][N_SAMP];
    logic signed [31:0] wgt_mem [N_SAMP];
    logic signed [31:0] mean_mem [N_STATE];
    logic signed [31:0] cov_acc [N_TRI];
    logic signed [31:0] pending_reads [$];
    int                 failures = 0;

    assign o_failures = failures;
    assign o_pending  = pending_reads.size();

    function automatic logic signed [31:0] fx_mul(logic signed [31:0] a,
                                                   logic signed [31:0] b);
        logic signed [63:0] p;
        p = a * b;
        return p[47:16];
    endfunction

    // weighted means, then the upper triangle of weighted outer products
    task automatic update_moments();
        logic signed [31:0] sum;
        logic signed [31:0] diff [N_STATE];
        int                 k;
        for (int r = 0; r < N_STATE; r++) begin
            sum = '0;
            for (int p = 0; p < N_SAMP; p++)
                sum = sum + fx_mul(comp_mem[r][p], wgt_mem[p]);
            mean_mem[r] = sum;
        end
        foreach (cov_acc[k2]) cov_acc[k2] = '0;
        for (int p = 0; p < N_SAMP; p++) begin
            for (int r = 0; r < N_STATE; r++)
                diff[r] = comp_mem[r][p] - mean_mem[r];
            k = 0;
            for (int i = 0; i < N_STATE; i++) begin
                for (int j = i; j < N_STATE; j++) begin
                    cov_acc[k] = cov_acc[k] + fx_mul(fx_mul(diff[i], diff[j]), wgt_mem[p]);
                    k++;
                end
            end
        end
    endtask

    function automatic logic signed [31:0] cov_entry(int r, int c);
        int lo, hi;
        if (r >= N_STATE || c >= N_STATE) return '0;
        lo = (r < c) ? r : c;
        hi = (r < c) ? c : r;
        return cov_acc[lo * N_STATE - (lo * (lo - 1)) / 2 + (hi - lo)];
    endfunction

    initial begin
        foreach (mean_mem[i]) mean_mem[i] = '0;
        foreach (cov_acc[i]) cov_acc[i] = '0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && i_in_ready) begin
            case (i_action)
                wmc_pkg::ACT_LOAD_COMP: begin
                    if (i_row_index < N_STATE)
                        comp_mem[i_row_index][i_particle_index] = i_sample_value;
                end
                wmc_pkg::ACT_LOAD_WGT:  wgt_mem[i_particle_index] = i_sample_value;
                wmc_pkg::ACT_COMPUTE:   update_moments();
                wmc_pkg::ACT_READ_MEAN: begin
                    pending_reads.push_back((i_row_index < N_STATE) ?
                                            mean_mem[i_row_index] : 32'sd0);
                end
                wmc_pkg::ACT_READ_COV:
                    pending_reads.push_back(cov_entry(i_row_index, i_column_index));
                default: ;
            endcase
        end
        if (i_rst_n && i_out_valid && i_out_ready) begin
            if (pending_reads.size() == 0) begin
                $error("read_value: unexpected result %0d", i_read_value);
                failures++;
            end else begin
                if (i_read_value !== pending_reads[0]) begin
                    $error("read_value: expected %0d, actual %0d",
                           pending_reads[0], i_read_value);
                    failures++;
                end
                void'(pending_reads.pop_front());
            end
        end
    end

endmodule

// File: sim/weighted_mean_covariance_top_tb.sv
// ----------------------------------------------------------------------------
// weighted_mean_covariance_top_tb
// Fills the particle and weight stores, runs compute requests and reads back
// every mean and covariance entry, mixed with random loads, reads and ignored
// requests under random stalls on both channels.
// ----------------------------------------------------------------------------
module weighted_mean_covariance_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          N_STATE     = 13;
    localparam int          N_SAMP      = 1024;
    localparam int          STALL_LIMIT = 1500000;
    localparam logic [2:0]  ACT_SPARE_A = 3'd5;
    localparam logic [2:0]  ACT_SPARE_B = 3'd6;
    localparam logic [2:0]  ACT_SPARE_C = 3'd7;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [2:0]         i_action = '0;
    logic [9:0]         i_particle_index = '0;
    logic [3:0]         i_row_index = '0;
    logic [3:0]         i_column_index = '0;
    logic signed [31:0] i_sample_value = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic signed [31:0] o_read_value;
    int                 failures;
    int                 pending;
    bit                 send_calm = 0;
    bit                 recv_calm = 0;
    int                 stall_cnt = 0;

    always #5 i_clk = ~i_clk;

    weighted_mean_covariance_top dut (.*);

    weighted_mean_covariance_checker u_checker (
        .i_clk, .i_rst_n, .i_in_valid,
        .i_in_ready(o_in_ready),
        .i_action, .i_particle_index, .i_row_index, .i_column_index, .i_sample_value,
        .i_out_valid(o_out_valid),
        .i_out_ready, .i_read_value(o_read_value),
        .o_failures(failures), .o_pending(pending)
    );

    function automatic int draw_gap(ref bit calm);
        if ($urandom_range(0, 149) == 0) calm = ~calm;
        return calm ? 0 : $urandom_range(0, 17);
    endfunction

    function automatic logic signed [31:0] draw_value();
        case ($urandom_range(0, 5))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2, 3:    return $urandom();
            default: return $signed($urandom_range(0, 32'h3_ffff)) - 32'sh2_0000;
        endcase
    endfunction

    task automatic send_request(int unsigned act, int unsigned pidx, int unsigned row,
                                int unsigned col, logic signed [31:0] val);
        int gap;
        gap = draw_gap(send_calm);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_action         <= 3'(act);
        i_particle_index <= 10'(pidx);
        i_row_index      <= 4'(row);
        i_column_index   <= 4'(col);
        i_sample_value   <= val;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic read_all();
        for (int r = 0; r < N_STATE; r++)
            send_request(wmc_pkg::ACT_READ_MEAN, $urandom(), r, $urandom(), $urandom());
        for (int r = 0; r < N_STATE; r++)
            for (int c = 0; c < N_STATE; c++)
                send_request(wmc_pkg::ACT_READ_COV, $urandom(), r, c, $urandom());
    endtask

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            gap = draw_gap(recv_calm);
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    initial begin
        int pick;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reads before any compute, out of range reads, ignored requests
        send_request(wmc_pkg::ACT_READ_MEAN, '0, 4'd0, 4'd0, '0);
        send_request(wmc_pkg::ACT_READ_MEAN, 10'h3ff, 4'd15, 4'd15, '1);
        send_request(wmc_pkg::ACT_READ_COV, '0, 4'd0, 4'd12, '0);
        send_request(wmc_pkg::ACT_READ_COV, '0, 4'd12, 4'd0, '0);
        send_request(wmc_pkg::ACT_READ_COV, '0, 4'd13, 4'd2, '0);
        send_request(wmc_pkg::ACT_READ_COV, '0, 4'd3, 4'd15, '0);
        send_request(ACT_SPARE_A, 10'd5, 4'd1, 4'd1, 32'sd1);
        send_request(ACT_SPARE_B, 10'h3ff, 4'hf, 4'hf, '1);
        send_request(ACT_SPARE_C, '0, '0, '0, '0);
        send_request(wmc_pkg::ACT_LOAD_COMP, 10'd7, 4'd13, '0, 32'sd99);
        send_request(wmc_pkg::ACT_LOAD_COMP, 10'h3ff, 4'd15, 4'hf, '1);

        // fill every store entry before the first compute
        for (int p = 0; p < N_SAMP; p++) begin
            for (int r = 0; r < N_STATE; r++)
                send_request(wmc_pkg::ACT_LOAD_COMP, p, r, $urandom(), draw_value());
            send_request(wmc_pkg::ACT_LOAD_WGT, p, $urandom(), $urandom(),
                         (p < 2) ? ((p == 0) ? 32'sh7fff_ffff : 32'sh8000_0000)
                                 : $signed($urandom_range(0, 255)));
        end
        send_request(wmc_pkg::ACT_COMPUTE, $urandom(), $urandom(), $urandom(), $urandom());
        read_all();

        for (int n = 0; n < 1750; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
                send_request(wmc_pkg::ACT_LOAD_COMP, $urandom(),
                             $urandom_range(0, N_STATE - 1), $urandom(), draw_value());
            else if (pick < 50)
                send_request(wmc_pkg::ACT_LOAD_WGT, $urandom(), $urandom(), $urandom(),
                             ($urandom_range(0, 9) == 0) ? draw_value()
                                                         : $signed($urandom_range(0, 255)));
            else if (pick < 70)
                send_request(wmc_pkg::ACT_READ_MEAN, $urandom(), $urandom(), $urandom(),
                             $urandom());
            else if (pick < 92)
                send_request(wmc_pkg::ACT_READ_COV, $urandom(),
                             ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 12),
                             ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 12),
                             $urandom());
            else if (pick < 96)
                send_request(wmc_pkg::ACT_LOAD_COMP, $urandom(), $urandom_range(N_STATE, 15),
                             $urandom(), $urandom());
            else
                send_request($urandom_range(ACT_SPARE_A, ACT_SPARE_C), $urandom(),
                             $urandom(), $urandom(), $urandom());
        end
        send_request(wmc_pkg::ACT_COMPUTE, $urandom(), $urandom(), $urandom(), $urandom());
        read_all();
        i_in_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: filelist.f
rtl/wmc_pkg.sv
rtl/wmc_fxmul.sv
rtl/wmc_tri.sv
rtl/weighted_mean_covariance_top.sv
sim/weighted_mean_covariance_checker.sv
sim/weighted_mean_covariance_top_tb.sv
